// ----- design/wsd_pkg.sv -----
// Shared constants, request codes and controller/datapath interface types
// for the work-stealing deque. No dependencies.
`default_nettype none

package wsd_pkg;

   // storage geometry
   localparam int unsigned QUEUE_DEPTH = 256;
   localparam int unsigned HANDLE_BITS = 32;
   localparam int unsigned ADDR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int unsigned INDEX_BITS  = $clog2(QUEUE_DEPTH + 1);

   // port widths fixed by the interface
   localparam int unsigned JOB_BITS      = 32;
   localparam int unsigned REQ_BITS      = 2;
   localparam int unsigned CFG_BITS      = 9;
   localparam int unsigned CSR_ADDR_BITS = 3;
   localparam int unsigned CSR_DATA_BITS = 32;

   // width used when comparing an index against the capacity register
   localparam int unsigned CMP_BITS = (CFG_BITS > INDEX_BITS) ? CFG_BITS : INDEX_BITS;

   localparam logic [CFG_BITS-1:0] CAPACITY_RESET = CFG_BITS'(256);

   // register index, taken from paddr[2]
   localparam logic CSR_IDX_CAPACITY = 1'b0;

   typedef enum logic [REQ_BITS-1:0] {
      REQ_PUSH  = 2'd0,
      REQ_POP   = 2'd1,
      REQ_STEAL = 2'd2,
      REQ_CLEAR = 2'd3
   } req_code_type;

   typedef struct packed {
      logic latch;   // capture the incoming word
      logic exec;    // update indices, write or read the store
      logic load;    // move the result into the output register
   } wsd_cmd_type;

   typedef struct packed {
      logic out_free;  // output register empty or being taken this cycle
   } wsd_sts_type;

endpackage

`default_nettype wire

// ----- design/work_stealing_deque.sv -----
// Top level of the work-stealing deque: config registers, controller, datapath.
// Depends on wsd_pkg, wsd_csr, wsd_ctrl, wsd_dp.
//
//   channel   direction  handshake                         payload
//   req       in         req_valid / req_stall             req_type, req_job_in
//   rsp       out        rsp_valid / rsp_stall             rsp_success, rsp_job_out
//   csr       in/out     csr_psel, csr_penable, csr_pready capacity_in_use at 0x0
//
// One word at a time: accept, execute (index update plus store write or
// registered store read), then load the output register, which waits while
// a held result has not yet been taken.
// A result may wait in the output register while the next word is accepted.
// Synchronous reset clears both indices and sets capacity to 256; the job
// store is not cleared.
`default_nettype none

module work_stealing_deque
   import wsd_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire logic [REQ_BITS-1:0]      req_type,
   input  wire logic [JOB_BITS-1:0]      req_job_in,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output logic                          rsp_success,
   output logic      [JOB_BITS-1:0]      rsp_job_out,
   input  wire logic                     csr_psel,
   input  wire logic                     csr_penable,
   input  wire logic                     csr_pwrite,
   input  wire logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  wire logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic      [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                          csr_pready
);

   wsd_cmd_type         cmd;
   wsd_sts_type         sts;
   logic [CFG_BITS-1:0] capacity;

   wsd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .capacity    (capacity)
   );

   wsd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   wsd_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .capacity    (capacity),
      .req_type    (req_type),
      .req_job_in  (req_job_in),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_success (rsp_success),
      .rsp_job_out (rsp_job_out)
   );

endmodule

`default_nettype wire

// ----- design/wsd_csr.sv -----
// APB-style configuration register block: holds capacity_in_use.
// Depends on wsd_pkg.
`default_nettype none

module wsd_csr
   import wsd_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     csr_psel,
   input  wire logic                     csr_penable,
   input  wire logic                     csr_pwrite,
   input  wire logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  wire logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic      [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                          csr_pready,
   output logic      [CFG_BITS-1:0]      capacity
);

   logic [CFG_BITS-1:0] capacity_ff;
   logic [CFG_BITS-1:0] capacity_in;
   logic                wr_hit;

   assign csr_pready = 1'b1;
   assign wr_hit = csr_psel && csr_penable && csr_pwrite && csr_pready
                   && (csr_paddr[2] == CSR_IDX_CAPACITY);
   assign capacity_in = wr_hit ? csr_pwdata[CFG_BITS-1:0] : capacity_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAPACITY_RESET;
      end else begin
         capacity_ff <= capacity_in;
      end
   end

   always_comb begin
      if (csr_paddr[2] == CSR_IDX_CAPACITY) begin
         csr_prdata = CSR_DATA_BITS'(capacity_ff);
      end else begin
         csr_prdata = '0;
      end
   end

   assign capacity = capacity_ff;

endmodule

`default_nettype wire

// ----- design/wsd_ctrl.sv -----
// Sequencing state machine: accept one word, execute it, hand off the result.
// Depends on wsd_pkg.
`default_nettype none

module wsd_ctrl
   import wsd_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire wsd_sts_type sts,
   output wsd_cmd_type      cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_LOAD
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            if (sts.out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall  = (state_ff != ST_IDLE);
   assign cmd.latch  = (state_ff == ST_IDLE) && req_valid;
   assign cmd.exec   = (state_ff == ST_EXEC);
   assign cmd.load   = (state_ff == ST_LOAD) && sts.out_free;

endmodule

`default_nettype wire

// ----- design/wsd_dp.sv -----
// Datapath: request capture, bottom/top index registers, job store memory
// and the output register. Depends on wsd_pkg.
`default_nettype none

module wsd_dp
   import wsd_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire wsd_cmd_type         cmd,
   output wsd_sts_type              sts,
   input  wire logic [CFG_BITS-1:0] capacity,
   input  wire logic [REQ_BITS-1:0] req_type,
   input  wire logic [JOB_BITS-1:0] req_job_in,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic                     rsp_success,
   output logic      [JOB_BITS-1:0] rsp_job_out
);

   logic [REQ_BITS-1:0]    req_type_ff;
   logic [HANDLE_BITS-1:0] job_in_ff;
   logic [INDEX_BITS-1:0]  bottom_ff, bottom_in;
   logic [INDEX_BITS-1:0]  top_ff, top_in;
   logic                   ok_ff, ok_in;
   logic                   from_mem_ff, from_mem_in;

   logic [HANDLE_BITS-1:0] mem [QUEUE_DEPTH];
   logic [HANDLE_BITS-1:0] rd_data_ff;
   logic                   wr_en, rd_en;
   logic [ADDR_BITS-1:0]   wr_addr, rd_addr;

   logic                   rsp_valid_ff;
   logic                   rsp_success_ff;
   logic [JOB_BITS-1:0]    rsp_job_ff;

   logic [CMP_BITS-1:0]    cap_sat;
   logic [INDEX_BITS-1:0]  bottom_m1;

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         req_type_ff <= req_type;
         job_in_ff   <= HANDLE_BITS'(req_job_in);
      end
   end

   // capacity above the store depth acts as the full depth
   always_comb begin
      if (CMP_BITS'(capacity) > CMP_BITS'(QUEUE_DEPTH)) begin
         cap_sat = CMP_BITS'(QUEUE_DEPTH);
      end else begin
         cap_sat = CMP_BITS'(capacity);
      end
   end

   assign bottom_m1 = bottom_ff - INDEX_BITS'(1);

   always_comb begin
      bottom_in   = bottom_ff;
      top_in      = top_ff;
      ok_in       = 1'b0;
      from_mem_in = 1'b0;
      wr_en       = 1'b0;
      rd_en       = 1'b0;
      wr_addr     = bottom_ff[ADDR_BITS-1:0];
      rd_addr     = top_ff[ADDR_BITS-1:0];
      case (req_type_ff)
         REQ_PUSH: begin
            if (CMP_BITS'(bottom_ff) < cap_sat) begin
               wr_en     = cmd.exec;
               bottom_in = bottom_ff + INDEX_BITS'(1);
               ok_in     = 1'b1;
            end
         end
         REQ_POP: begin
            if (bottom_ff != '0) begin
               if (top_ff <= bottom_m1) begin
                  rd_en       = cmd.exec;
                  rd_addr     = bottom_m1[ADDR_BITS-1:0];
                  ok_in       = 1'b1;
                  from_mem_in = 1'b1;
                  // last item taken: both indices move past it
                  if (top_ff == bottom_m1) begin
                     top_in    = bottom_ff;
                     bottom_in = bottom_ff;
                  end else begin
                     bottom_in = bottom_m1;
                  end
               end else begin
                  bottom_in = top_ff;
               end
            end
         end
         REQ_STEAL: begin
            if (top_ff < bottom_ff) begin
               rd_en       = cmd.exec;
               top_in      = top_ff + INDEX_BITS'(1);
               ok_in       = 1'b1;
               from_mem_in = 1'b1;
            end
         end
         REQ_CLEAR: begin
            bottom_in = '0;
            top_in    = '0;
            ok_in     = 1'b1;
         end
         default: begin
            ok_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bottom_ff <= '0;
         top_ff    <= '0;
      end else if (cmd.exec) begin
         bottom_ff <= bottom_in;
         top_ff    <= top_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         ok_ff       <= ok_in;
         from_mem_ff <= from_mem_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= job_in_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rsp_success_ff <= ok_ff;
         rsp_job_ff     <= from_mem_ff ? JOB_BITS'(rd_data_ff) : '0;
      end
   end

   assign sts.out_free = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_success  = rsp_success_ff;
   assign rsp_job_out  = rsp_job_ff;

endmodule

`default_nettype wire

// ----- design/wsd_checker.sv -----
// Port-level checks for work_stealing_deque, bound to the top level.
// Depends on wsd_pkg.
`default_nettype none

module wsd_checker
   import wsd_pkg::*;
(
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                req_valid,
   input wire logic                req_stall,
   input wire logic                rsp_valid,
   input wire logic                rsp_stall,
   input wire logic                rsp_success,
   input wire logic [JOB_BITS-1:0] rsp_job_out
);

   // a held result word keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_job_out) && $stable(rsp_success))
      else $error("rsp word changed while stalled");

   // failed requests carry no job
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_success |-> rsp_job_out == '0)
      else $error("failed result carries a nonzero job");

   // one request in flight: stall follows every accepted word
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second word accepted while one is in flight");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid high right after reset");

endmodule

bind work_stealing_deque wsd_checker u_wsd_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_success (rsp_success),
   .rsp_job_out (rsp_job_out)
);

`default_nettype wire

// ----- tb/deque_result_checker.sv -----
// Result checker for the work-stealing deque: watches the request, result and
// register ports, predicts each result word and compares it. Depends on wsd_pkg.
module deque_result_checker
   import wsd_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_stall,
   input  logic [REQ_BITS-1:0]      req_type,
   input  logic [JOB_BITS-1:0]      req_job_in,
   input  logic                     rsp_valid,
   input  logic                     rsp_stall,
   input  logic                     rsp_success,
   input  logic [JOB_BITS-1:0]      rsp_job_out,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   input  logic [CSR_DATA_BITS-1:0] csr_prdata,
   input  logic                     csr_pready,
   output int                       fail_count,
   output int                       pending_words
);

   typedef struct packed {
      logic                success;
      logic [JOB_BITS-1:0] job;
   } deque_outcome_type;

   deque_outcome_type   outcome_q [$];
   logic [JOB_BITS-1:0] job_slots [QUEUE_DEPTH];
   logic [CFG_BITS-1:0] capacity;
   logic [8:0]          bottom_idx;
   logic [8:0]          top_idx;
   int                  mismatches = 0;
   int                  waiting = 0;

   assign fail_count    = mismatches;
   assign pending_words = waiting;

   initial begin
      foreach (job_slots[i]) job_slots[i] = '0;
   end

   task automatic deque_step(input req_code_type code, input logic [JOB_BITS-1:0] job,
                             output deque_outcome_type res);
      logic [8:0] limit;
      logic [8:0] last;
      res = '0;
      limit = (capacity > 9'd256) ? 9'd256 : capacity;
      case (code)
         REQ_PUSH: begin
            if (bottom_idx < limit) begin
               job_slots[bottom_idx[ADDR_BITS-1:0]] = job;
               bottom_idx = bottom_idx + 9'd1;
               res.success = 1'b1;
            end
         end
         REQ_POP: begin
            // bottom at zero: nothing to pop, indices untouched
            if (bottom_idx != 9'd0) begin
               last = bottom_idx - 9'd1;
               if (top_idx <= last) begin
                  res.job = job_slots[last[ADDR_BITS-1:0]];
                  res.success = 1'b1;
                  if (top_idx == last) begin
                     // took the last word: both indices move past it
                     top_idx = last + 9'd1;
                     bottom_idx = last + 9'd1;
                  end else begin
                     bottom_idx = last;
                  end
               end else begin
                  bottom_idx = top_idx;
               end
            end
         end
         REQ_STEAL: begin
            if (top_idx < bottom_idx) begin
               res.job = job_slots[top_idx[ADDR_BITS-1:0]];
               top_idx = top_idx + 9'd1;
               res.success = 1'b1;
            end
         end
         default: begin
            bottom_idx = '0;
            top_idx = '0;
            res.success = 1'b1;
         end
      endcase
   endtask

   always @(posedge clock) begin
      deque_outcome_type want;
      deque_outcome_type next;
      if (reset) begin
         bottom_idx = '0;
         top_idx = '0;
         capacity = CAPACITY_RESET;
         outcome_q.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pready && csr_paddr[2] == CSR_IDX_CAPACITY) begin
            if (csr_pwrite) begin
               capacity = csr_pwdata[CFG_BITS-1:0];
            end else if (csr_prdata !== CSR_DATA_BITS'(capacity)) begin
               $display("%0t: capacity read exp %0d got %0d", $time, capacity, csr_prdata);
               mismatches++;
            end
         end
         // result first: a word accepted this edge cannot answer itself
         if (rsp_valid && !rsp_stall) begin
            if (outcome_q.size() == 0) begin
               $display("%0t: result word exp none got success %0b job %h", $time,
                        rsp_success, rsp_job_out);
               mismatches++;
            end else begin
               want = outcome_q.pop_front();
               if (rsp_success !== want.success) begin
                  $display("%0t: success exp %0b got %0b", $time, want.success, rsp_success);
                  mismatches++;
               end
               if (rsp_job_out !== want.job) begin
                  $display("%0t: job_out exp %h got %h", $time, want.job, rsp_job_out);
                  mismatches++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            deque_step(req_code_type'(req_type), req_job_in, next);
            outcome_q.push_back(next);
         end
      end
      waiting = outcome_q.size();
   end

endmodule

// ----- tb/tb_work_stealing_deque.sv -----
// Testbench top for the work-stealing deque: clock, reset, stimulus, register
// writes and verdict. Depends on wsd_pkg, work_stealing_deque, deque_result_checker.
module tb_work_stealing_deque;
   import wsd_pkg::*;

   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int NUM_PHASES  = 10;
   localparam int HOLD_CYCLES = 300;
   localparam logic [CSR_ADDR_BITS-1:0] CAPACITY_ADDR = '0;

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_stall;
   logic [REQ_BITS-1:0]      req_type;
   logic [JOB_BITS-1:0]      req_job_in;
   logic                     rsp_valid;
   logic                     rsp_stall;
   logic                     rsp_success;
   logic [JOB_BITS-1:0]      rsp_job_out;
   logic                     csr_psel;
   logic                     csr_penable;
   logic                     csr_pwrite;
   logic [CSR_ADDR_BITS-1:0] csr_paddr;
   logic [CSR_DATA_BITS-1:0] csr_pwdata;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic                     csr_pready;

   int fail_count;
   int pending_words;
   int cycle_count;
   int no_gap_left;
   bit pressure_armed;
   bit pressure_done;

   // phase 0 runs long and push-heavy to drive the deque towards full capacity
   int unsigned phase_cap [NUM_PHASES] = '{256, 1, 0, 511, 3, 17, 256, 300, 128, 2};

   work_stealing_deque DUT (.*);

   deque_result_checker result_chk (
      .clock, .reset, .req_valid, .req_stall, .req_type, .req_job_in,
      .rsp_valid, .rsp_stall, .rsp_success, .rsp_job_out,
      .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr, .csr_pwdata,
      .csr_prdata, .csr_pready, .fail_count, .pending_words
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic logic [JOB_BITS-1:0] rand_handle();
      int unsigned r;
      r = $urandom_range(0, 15);
      if (r == 0) return '0;
      if (r == 1) return '1;
      return $urandom;
   endfunction

   task automatic send_word(input req_code_type code, input logic [JOB_BITS-1:0] job);
      int unsigned r;
      int gap;
      gap = 0;
      if (no_gap_left > 0) begin
         no_gap_left--;
      end else begin
         r = $urandom_range(0, 99);
         if (r < 3) no_gap_left = $urandom_range(30, 80);
         else if (r < 60) gap = 0;
         else if (r < 90) gap = $urandom_range(1, 3);
         else if (r < 99) gap = $urandom_range(4, 10);
         else gap = $urandom_range(20, 60);
      end
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid  <= 1'b1;
      req_type   <= code;
      req_job_in <= job;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_words != 0) @(negedge clock);
   endtask

   // register write followed by a read-back, only with the block drained
   task automatic write_capacity(input logic [CFG_BITS-1:0] value);
      wait_drained();
      repeat (4) @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CAPACITY_ADDR;
      csr_pwdata  <= CSR_DATA_BITS'(value);
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // result side: short and long holds, quiet stretches, one long pressure hold
   initial begin
      int unsigned r;
      int run_len;
      int stall_len;
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (pressure_armed && !pressure_done) begin
            pressure_done = 1'b1;
            run_len = 1;
            stall_len = HOLD_CYCLES;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 20) begin
               run_len = $urandom_range(50, 200);
               stall_len = 0;
            end else if (r < 80) begin
               run_len = $urandom_range(1, 8);
               stall_len = $urandom_range(1, 3);
            end else begin
               run_len = $urandom_range(1, 10);
               stall_len = $urandom_range(8, 40);
            end
         end
         repeat (run_len) begin
            @(negedge clock);
            rsp_stall <= 1'b0;
         end
         repeat (stall_len) begin
            @(negedge clock);
            rsp_stall <= 1'b1;
         end
      end
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb_work_stealing_deque failed");
      $finish;
   end

   initial begin
      int unsigned r;
      int unsigned items;
      int unsigned push_pm;
      int unsigned pop_pm;
      int unsigned clear_pm;
      req_code_type code;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_type       = REQ_PUSH;
      req_job_in     = '0;
      csr_psel       = 1'b0;
      csr_penable    = 1'b0;
      csr_pwrite     = 1'b0;
      csr_paddr      = '0;
      csr_pwdata     = '0;
      no_gap_left    = 0;
      pressure_armed = 1'b0;
      pressure_done  = 1'b0;
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      // empty deque corners, then handle extremes at both ends
      send_word(REQ_POP, rand_handle());
      send_word(REQ_STEAL, rand_handle());
      send_word(REQ_PUSH, 32'h0000_0000);
      send_word(REQ_PUSH, 32'hFFFF_FFFF);
      send_word(REQ_PUSH, 32'hA5A5_A5A5);
      send_word(REQ_POP, rand_handle());
      send_word(REQ_STEAL, rand_handle());
      send_word(REQ_STEAL, rand_handle());
      send_word(REQ_STEAL, rand_handle());
      send_word(REQ_POP, rand_handle());
      send_word(REQ_PUSH, 32'h5A5A_5A5A);
      send_word(REQ_POP, rand_handle());
      send_word(REQ_PUSH, rand_handle());
      send_word(REQ_PUSH, rand_handle());
      // capacity dropped under the bottom index: push fails, removal still works
      write_capacity(CFG_BITS'(2));
      send_word(REQ_PUSH, rand_handle());
      send_word(REQ_STEAL, rand_handle());
      send_word(REQ_POP, rand_handle());
      write_capacity(CFG_BITS'(0));
      send_word(REQ_CLEAR, rand_handle());
      send_word(REQ_PUSH, rand_handle());
      write_capacity(CFG_BITS'(511));
      send_word(REQ_PUSH, rand_handle());
      write_capacity(CFG_BITS'(1));
      send_word(REQ_PUSH, rand_handle());
      send_word(REQ_PUSH, rand_handle());
      send_word(REQ_POP, rand_handle());
      send_word(REQ_PUSH, rand_handle());
      send_word(REQ_CLEAR, rand_handle());

      for (int p = 0; p < NUM_PHASES; p++) begin
         write_capacity(CFG_BITS'(phase_cap[p]));
         if (p == 0) begin
            pressure_armed = 1'b1;
            items = 400;
            clear_pm = 1;
            push_pm = 700;
            pop_pm = 120;
         end else begin
            items = 100;
            clear_pm = 40;
            push_pm = 450;
            pop_pm = 250;
         end
         for (int i = 0; i < items; i++) begin
            r = $urandom_range(0, 999);
            if (r < clear_pm) code = REQ_CLEAR;
            else if (r < clear_pm + push_pm) code = REQ_PUSH;
            else if (r < clear_pm + push_pm + pop_pm) code = REQ_POP;
            else code = REQ_STEAL;
            send_word(code, rand_handle());
         end
      end

      wait_drained();
      repeat (20) @(negedge clock);
      if (fail_count == 0 && pending_words == 0) begin
         $display("tb_work_stealing_deque passed");
      end else begin
         $display("tb_work_stealing_deque failed");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
design/wsd_pkg.sv
design/wsd_csr.sv
design/wsd_ctrl.sv
design/wsd_dp.sv
design/work_stealing_deque.sv
design/wsd_checker.sv
tb/deque_result_checker.sv
tb/tb_work_stealing_deque.sv
